### hdl/dtd_pkg.sv
// Shared types, codes and constants of the double tap detector.
package dtd_pkg;

    localparam int TIME_W    = 27;
    localparam int PTS_W     = 4;
    localparam int POS_W     = 16;
    localparam int DIST_W    = 10;
    localparam int TIMEOUT_W = 16;
    localparam int TAP_W     = 2;
    localparam int SQ_W      = 2 * POS_W;
    localparam int LIM_W     = 2 * DIST_W;

    localparam logic [DIST_W-1:0]    RADIUS_RST       = 10'd30;
    localparam logic [TIMEOUT_W-1:0] WINDOW_RST       = 16'd500;
    localparam logic [TAP_W-1:0]     TAP_COUNT_MAX    = 2'd3;
    localparam logic [PTS_W-1:0]     SINGLE_POINT     = 4'd1;

    localparam logic [0:0] CFG_RADIUS = 1'b0;
    localparam logic [0:0] CFG_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_END    = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_OTHER  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_IGNORE = 2'd0,
        VERDICT_MAYBE  = 2'd1,
        VERDICT_FINISH = 2'd2,
        VERDICT_CANCEL = 2'd3
    } verdict_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     for_watched;
        logic [TIME_W-1:0]        time_ms;
        logic [PTS_W-1:0]         point_count;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
    } dtd_in_t;

    // Event decision, with a pending distance test when cand is set.
    typedef struct packed {
        verdict_t                 verdict;
        logic                     cand;
        logic signed [POS_W:0]    dx;
        logic signed [POS_W:0]    dy;
        logic signed [POS_W-1:0]  gx;
        logic signed [POS_W-1:0]  gy;
    } dtd_s1_t;

    typedef struct packed {
        verdict_t                 verdict;
        logic signed [POS_W-1:0]  gx;
        logic signed [POS_W-1:0]  gy;
    } dtd_out_t;

endpackage

### hdl/dtd_ctrl.sv
// Gesture state and per-event decision stage of the double tap detector.
module dtd_ctrl
    import dtd_pkg::*;
#(
    parameter int MAX_TOUCH_POINTS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dtd_in_t              in_item,
    input  logic [TIMEOUT_W-1:0] window_ms,
    input  logic                 take_s1,
    output logic                 s1_valid,
    output dtd_s1_t              s1_item
);

    localparam logic [PTS_W-1:0] MAX_PTS = PTS_W'(MAX_TOUCH_POINTS);

    logic [TAP_W-1:0]        tap_count_reg, tap_count_next;
    logic [TIME_W-1:0]       press_time_reg, press_time_next;
    logic signed [POS_W-1:0] press_x_reg, press_x_next;
    logic signed [POS_W-1:0] press_y_reg, press_y_next;
    logic [PTS_W-1:0]        touch_count_reg, touch_count_next;
    logic                    first_pressed_reg, first_pressed_next;
    logic                    s1_valid_reg;
    dtd_s1_t                 s1_reg, s1_next;

    logic [TIME_W:0]         elapsed;
    logic                    expired;
    logic [TAP_W-1:0]        tap_eff;
    logic                    accept;

    assign in_ready = !s1_valid_reg || take_s1;
    assign accept   = in_valid && in_ready;
    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_reg;

    // Negative elapsed time never expires.
    assign elapsed = {1'b0, in_item.time_ms} - {1'b0, press_time_reg};
    assign expired = !elapsed[TIME_W]
                     && (elapsed[TIME_W-1:0] > TIME_W'(window_ms));

    always_comb
    begin
        tap_count_next     = tap_count_reg;
        press_time_next    = press_time_reg;
        press_x_next       = press_x_reg;
        press_y_next       = press_y_reg;
        touch_count_next   = touch_count_reg;
        first_pressed_next = first_pressed_reg;
        tap_eff            = tap_count_reg;
        s1_next.verdict    = VERDICT_IGNORE;
        s1_next.cand       = 1'b0;
        s1_next.dx = $signed({in_item.pos_x[POS_W-1], in_item.pos_x})
                   - $signed({press_x_reg[POS_W-1], press_x_reg});
        s1_next.dy = $signed({in_item.pos_y[POS_W-1], in_item.pos_y})
                   - $signed({press_y_reg[POS_W-1], press_y_reg});
        s1_next.gx = press_x_reg;
        s1_next.gy = press_y_reg;
        if (in_item.for_watched)
        begin
            unique case (in_item.kind)
                KIND_BEGIN:
                begin
                    if (expired && (tap_count_reg != '0))
                    begin
                        tap_eff = '0;
                    end
                    tap_count_next = tap_eff;
                    if (tap_eff == '0)
                    begin
                        if (in_item.point_count == SINGLE_POINT)
                        begin
                            press_time_next    = in_item.time_ms;
                            press_x_next       = in_item.pos_x;
                            press_y_next       = in_item.pos_y;
                            touch_count_next   = SINGLE_POINT;
                            first_pressed_next = 1'b1;
                            s1_next.verdict    = VERDICT_MAYBE;
                        end
                    end
                    else
                    begin
                        s1_next.verdict    = VERDICT_CANCEL;
                        s1_next.cand       = (touch_count_reg == SINGLE_POINT)
                                             && (in_item.point_count == SINGLE_POINT);
                        tap_count_next     = '0;
                        first_pressed_next = 1'b0;
                    end
                end
                KIND_END:
                begin
                    if (first_pressed_reg && (tap_count_reg < TAP_COUNT_MAX))
                    begin
                        tap_count_next = tap_count_reg + TAP_W'(1);
                    end
                end
                KIND_UPDATE:
                begin
                    if (in_item.point_count != SINGLE_POINT)
                    begin
                        touch_count_next   = (in_item.point_count > MAX_PTS)
                                             ? MAX_PTS : in_item.point_count;
                        tap_count_next     = '0;
                        first_pressed_next = 1'b0;
                        s1_next.verdict    = VERDICT_CANCEL;
                    end
                end
                KIND_OTHER:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg     <= '0;
            touch_count_reg   <= '0;
            first_pressed_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tap_count_reg     <= tap_count_next;
                touch_count_reg   <= touch_count_next;
                first_pressed_reg <= first_pressed_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            press_time_reg <= press_time_next;
            press_x_reg    <= press_x_next;
            press_y_reg    <= press_y_next;
        end
        if (in_ready)
        begin
            s1_reg <= s1_next;
        end
    end

    a_taps_need_press: assert property (@(posedge clk) disable iff (!rst_n)
        (tap_count_reg != '0) |-> first_pressed_reg)
        else $error("tap count nonzero without a recorded press");

    a_touch_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        touch_count_reg <= MAX_PTS)
        else $error("touch count above the touch point limit");

    a_maybe_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s1_next.verdict == VERDICT_MAYBE))
        |=> (first_pressed_reg && (tap_count_reg == '0)))
        else $error("single press did not arm the detector");

endmodule

### hdl/dtd_dist.sv
// Distance test pipeline and result register of the double tap detector.
module dtd_dist
    import dtd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  dtd_s1_t           s1_item,
    output logic              take_s1,
    input  logic [DIST_W-1:0] radius_px,
    output logic              out_valid,
    input  logic              out_ready,
    output dtd_out_t          out_item
);

    logic signed [SQ_W+1:0] prod_x, prod_y;
    logic [SQ_W-1:0]        sq_x_reg, sq_y_reg;
    logic [LIM_W-1:0]       lim_reg;
    logic                   cand_reg;
    verdict_t               verdict_reg;
    logic signed [POS_W-1:0] gx_reg, gy_reg;
    logic                   s2_valid_reg;
    logic                   out_valid_reg;
    dtd_out_t               out_reg, out_next;
    logic [SQ_W:0]          dist_sq;
    logic                   near;
    logic                   take_s2;

    assign take_s2   = !out_valid_reg || out_ready;
    assign take_s1   = !s2_valid_reg || take_s2;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Squares of 17-bit differences fit in 32 unsigned bits.
    assign prod_x = s1_item.dx * s1_item.dx;
    assign prod_y = s1_item.dy * s1_item.dy;

    assign dist_sq = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign near    = dist_sq <= (SQ_W + 1)'(lim_reg);

    always_comb
    begin
        out_next.verdict = verdict_reg;
        out_next.gx      = '0;
        out_next.gy      = '0;
        if (cand_reg && near)
        begin
            out_next.verdict = VERDICT_FINISH;
            out_next.gx      = gx_reg;
            out_next.gy      = gy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_s1)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (take_s2)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_s1)
        begin
            sq_x_reg    <= prod_x[SQ_W-1:0];
            sq_y_reg    <= prod_y[SQ_W-1:0];
            lim_reg     <= LIM_W'(radius_px) * LIM_W'(radius_px);
            cand_reg    <= s1_item.cand;
            verdict_reg <= s1_item.verdict;
            gx_reg      <= s1_item.gx;
            gy_reg      <= s1_item.gy;
        end
        if (take_s2)
        begin
            out_reg <= out_next;
        end
    end

    a_finish_needs_test: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !cand_reg) |-> (verdict_reg != VERDICT_FINISH))
        else $error("finish verdict without a distance test");

    a_zero_when_not_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.verdict != VERDICT_FINISH))
        |-> ((out_reg.gx == '0) && (out_reg.gy == '0)))
        else $error("gesture position set on a non-finish result");

endmodule

### hdl/double_tap_detector.sv
// Top level of the double tap detector: stream ports, config registers, stages.
//
// Turns a stream of touch events into one verdict per event: ignore, maybe
// (a single-finger press armed the detector), finish (a second single-finger
// press came within the timeout window and within the distance radius of the
// first, reported with the first press position) or cancel. Events whose watched
// flag is clear, and events of the "other" kind, give ignore and leave the state
// alone. From the input transfer to the result transfer, the gesture state is
// updated in the cycle of the input transfer, the distance squares are formed
// in the next stage and summed and compared against the radius squared in the
// result stage. One event per cycle is sustained while the output is not
// stalled; each stage holds only while the one after it is full and stalled,
// so while a result waits the input keeps taking transfers until the two stages
// ahead of the result register are full. Write the configuration registers only
// while no event is in flight.
module double_tap_detector
    import dtd_pkg::*;
#(
    parameter int MAX_TOUCH_POINTS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Event input.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata, low bit up: time_ms[26:0], point_count[30:27], pos_x[46:31],
    // pos_y[62:47], zero pad[63]
    input  logic [63:0] s_tdata,
    // tuser, low bit up: req_type[1:0], for_watched[2]
    input  logic [2:0]  s_tuser,
    // Verdict output.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata, low bit up: gesture_x[15:0], gesture_y[31:16]
    output logic [31:0] m_tdata,
    // tuser, low bit up: verdict[1:0]
    output logic [1:0]  m_tuser,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [DIST_W-1:0]    radius_px_reg;
    logic [TIMEOUT_W-1:0] window_ms_reg;
    dtd_in_t              in_item;
    dtd_s1_t              s1_item;
    logic                 s1_valid;
    logic                 take_s1;
    dtd_out_t             out_item;

    // Unpack the event transfer into its fields.
    assign in_item.kind        = kind_t'(s_tuser[1:0]);
    assign in_item.for_watched = s_tuser[2];
    assign in_item.time_ms     = s_tdata[26:0];
    assign in_item.point_count = s_tdata[30:27];
    assign in_item.pos_x       = s_tdata[46:31];
    assign in_item.pos_y       = s_tdata[62:47];

    // Pack the result transfer.
    assign m_tuser = out_item.verdict;
    assign m_tdata = {out_item.gy, out_item.gx};

    // Configuration registers; writes land on the clock edge with no wait.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_px_reg <= RADIUS_RST;
            window_ms_reg <= WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_px_reg <= cfg_data[DIST_W-1:0];
                CFG_WINDOW: window_ms_reg <= cfg_data[TIMEOUT_W-1:0];
                default:    window_ms_reg <= window_ms_reg;
            endcase
        end
    end

    // Gesture state and decision: advance on every input transfer.
    dtd_ctrl #(
        .MAX_TOUCH_POINTS(MAX_TOUCH_POINTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .window_ms  (window_ms_reg),
        .take_s1    (take_s1),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    // Distance test and result register.
    dtd_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .take_s1     (take_s1),
        .radius_px   (radius_px_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_item    (out_item)
    );

endmodule
